/* design/tsjpc_pkg.sv */
`timescale 1ns / 1ps
// Package for the three-servo jog and position control block.
// Holds item codes, register indexes, reset limits and shared structs; no dependencies.
package tsjpc_pkg;

    localparam int unsigned POS_W = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [POS_W-1:0] RST_MIN = 16'd1638;
    localparam logic [POS_W-1:0] RST_MAX = 16'd8192;

    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef enum logic {
        FUNC_JOG    = 1'b0,
        FUNC_TARGET = 1'b1
    } t_func;

    typedef enum logic {
        MODE_JOG    = 1'b0,
        MODE_TARGET = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 3'd0,
        REG_SERVO1_MIN = 3'd1,
        REG_SERVO1_MAX = 3'd2,
        REG_SERVO2_MIN = 3'd3,
        REG_SERVO2_MAX = 3'd4,
        REG_SERVO3_MIN = 3'd5,
        REG_SERVO3_MAX = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_pos lo;
        t_pos hi;
    } t_limits;

    typedef struct packed {
        logic jog_en;
        logic tgt_en;
    } t_axis_ctl;

    typedef struct packed {
        t_pos duty_one;
        t_pos duty_two;
        t_pos duty_three;
    } t_result;

endpackage

/* design/tsjpc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input words and the result words.
// Depends on tsjpc_pkg for the payload widths.
interface tsjpc_in_if;
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [1:0]           dir_one;
    logic [1:0]           dir_two;
    logic [1:0]           dir_three;
    tsjpc_pkg::t_pos      speed_one;
    tsjpc_pkg::t_pos      speed_two;
    tsjpc_pkg::t_pos      speed_three;
    tsjpc_pkg::t_pos      target_one;
    tsjpc_pkg::t_pos      target_two;

    modport source (
        output valid, func, dir_one, dir_two, dir_three,
        output speed_one, speed_two, speed_three, target_one, target_two,
        input  ready
    );
    modport sink (
        input  valid, func, dir_one, dir_two, dir_three,
        input  speed_one, speed_two, speed_three, target_one, target_two,
        output ready
    );
endinterface

interface tsjpc_out_if;
    logic            valid;
    logic            ready;
    tsjpc_pkg::t_pos duty_one;
    tsjpc_pkg::t_pos duty_two;
    tsjpc_pkg::t_pos duty_three;

    modport source (output valid, duty_one, duty_two, duty_three, input ready);
    modport sink (input valid, duty_one, duty_two, duty_three, output ready);
endinterface

/* design/tsjpc_axis.sv */
`timescale 1ns / 1ps
// Next compare value of one servo: saturating jog step or bounded target take.
// Depends on tsjpc_pkg.
module tsjpc_axis (
    input  tsjpc_pkg::t_pos      i_pos,
    input  logic [1:0]           i_dir,
    input  tsjpc_pkg::t_pos      i_speed,
    input  tsjpc_pkg::t_pos      i_target,
    input  tsjpc_pkg::t_limits   i_limits,
    input  tsjpc_pkg::t_axis_ctl i_ctl,
    output tsjpc_pkg::t_pos      o_next
);
    import tsjpc_pkg::*;

    logic [POS_W:0] sum;
    t_pos           jog_pos;
    logic           tgt_ok;

    assign sum = {1'b0, i_pos} + {1'b0, i_speed};
    assign tgt_ok = (i_target != '0) && (i_target >= i_limits.lo) && (i_target <= i_limits.hi);

    always_comb begin
        case (i_dir)
            DIR_UP: begin
                jog_pos = (sum > {1'b0, i_limits.hi}) ? i_limits.hi : sum[POS_W-1:0];
            end
            DIR_DOWN: begin
                if ((i_speed > i_pos) || ((i_pos - i_speed) < i_limits.lo)) begin
                    jog_pos = i_limits.lo;
                end else begin
                    jog_pos = i_pos - i_speed;
                end
            end
            default: begin
                jog_pos = i_pos;
            end
        endcase
    end

    always_comb begin
        if (i_ctl.jog_en) begin
            o_next = jog_pos;
        end else if (i_ctl.tgt_en && tgt_ok) begin
            o_next = i_target;
        end else begin
            o_next = i_pos;
        end
    end

endmodule

/* design/tsjpc_out_buf.sv */
`timescale 1ns / 1ps
// Two-entry result buffer: an output register backed by a skid register.
// Depends on tsjpc_pkg for the result struct.
module tsjpc_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tsjpc_pkg::t_result i_data,
    output logic               o_full,
    output logic               o_valid,
    output tsjpc_pkg::t_result o_data,
    input  logic               i_ready
);
    import tsjpc_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    n_main_valid;
    logic    n_skid_valid;
    t_result n_main;
    t_result n_skid;
    logic    pop;

    assign pop     = r_main_valid && i_ready;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_main = i_data;
            end else begin
                n_main_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

`ifndef SYNTHESIS
    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("Skid register holds a word while the output register is empty.");
    a_fill_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_main_valid && !pop) |=> r_skid_valid)
        else $error("A word pushed behind a stalled output was lost.");
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !pop) |=> $stable(r_skid))
        else $error("Skid register changed while stalled.");
    a_skid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_skid_valid) |=> (r_main == $past(r_skid)))
        else $error("Skid word did not move into the output register.");
`endif

endmodule

/* design/three_servo_jog_position_control_top.sv */
`timescale 1ns / 1ps
// Top level of the three-servo jog and position control block.
// Depends on tsjpc_pkg, tsjpc_if, tsjpc_axis and tsjpc_out_buf.
//
//   Channel   Dir  Handshake            Word
//   i_in      in   valid/ready          func, dirs, speeds, targets
//   o_out     out  valid/ready          duty_one, duty_two, duty_three
//   i_cfg_*   in   write enable only    register index, 16-bit data
//
// One word is accepted per cycle while ready is high; its result is registered
// in the output register. The positions update in the accepting cycle, so a
// following word sees them at once. A word pushed behind a stalled output
// register waits in the skid register, and ready stays low while it waits.
// Reset sets the mode, limits, positions and buffer valid flags to reset values.
module three_servo_jog_position_control_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tsjpc_in_if.sink                       i_in,
    tsjpc_out_if.source                    o_out,
    input  logic                           i_cfg_we,
    input  logic [tsjpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  tsjpc_pkg::t_pos                i_cfg_data
);
    import tsjpc_pkg::*;

    logic      r_mode;
    t_limits   r_lim1;
    t_limits   r_lim2;
    t_limits   r_lim3;
    t_pos      r_pos1;
    t_pos      r_pos2;
    t_pos      r_pos3;
    t_pos      n_pos1;
    t_pos      n_pos2;
    t_pos      n_pos3;
    t_axis_ctl ctl12;
    t_axis_ctl ctl3;
    logic      accept;
    logic      buf_full;
    t_result   push_data;
    t_result   out_data;

    assign i_in.ready = !buf_full;
    assign accept     = i_in.valid && !buf_full;

    assign ctl12.jog_en = (i_in.func == FUNC_JOG) && (r_mode == MODE_JOG);
    assign ctl12.tgt_en = (i_in.func == FUNC_TARGET) && (r_mode == MODE_TARGET);
    assign ctl3.jog_en  = (i_in.func == FUNC_JOG);
    assign ctl3.tgt_en  = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_JOG;
            r_lim1.lo   <= RST_MIN;
            r_lim1.hi   <= RST_MAX;
            r_lim2.lo   <= RST_MIN;
            r_lim2.hi   <= RST_MAX;
            r_lim3.lo   <= RST_MIN;
            r_lim3.hi   <= RST_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:       r_mode    <= i_cfg_data[0];
                REG_SERVO1_MIN: r_lim1.lo <= i_cfg_data;
                REG_SERVO1_MAX: r_lim1.hi <= i_cfg_data;
                REG_SERVO2_MIN: r_lim2.lo <= i_cfg_data;
                REG_SERVO2_MAX: r_lim2.hi <= i_cfg_data;
                REG_SERVO3_MIN: r_lim3.lo <= i_cfg_data;
                REG_SERVO3_MAX: r_lim3.hi <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tsjpc_axis u_axis1 (
        .i_pos    (r_pos1),
        .i_dir    (i_in.dir_one),
        .i_speed  (i_in.speed_one),
        .i_target (i_in.target_one),
        .i_limits (r_lim1),
        .i_ctl    (ctl12),
        .o_next   (n_pos1)
    );

    tsjpc_axis u_axis2 (
        .i_pos    (r_pos2),
        .i_dir    (i_in.dir_two),
        .i_speed  (i_in.speed_two),
        .i_target (i_in.target_two),
        .i_limits (r_lim2),
        .i_ctl    (ctl12),
        .o_next   (n_pos2)
    );

    tsjpc_axis u_axis3 (
        .i_pos    (r_pos3),
        .i_dir    (i_in.dir_three),
        .i_speed  (i_in.speed_three),
        .i_target ('0),
        .i_limits (r_lim3),
        .i_ctl    (ctl3),
        .o_next   (n_pos3)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos1 <= RST_MIN;
            r_pos2 <= RST_MIN;
            r_pos3 <= RST_MAX;
        end else if (accept) begin
            r_pos1 <= n_pos1;
            r_pos2 <= n_pos2;
            r_pos3 <= n_pos3;
        end
    end

    assign push_data.duty_one   = n_pos1;
    assign push_data.duty_two   = n_pos2;
    assign push_data.duty_three = n_pos3;

    tsjpc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (push_data),
        .o_full  (buf_full),
        .o_valid (o_out.valid),
        .o_data  (out_data),
        .i_ready (o_out.ready)
    );

    assign o_out.duty_one   = out_data.duty_one;
    assign o_out.duty_two   = out_data.duty_two;
    assign o_out.duty_three = out_data.duty_three;

endmodule
